// ----- rtl/ustc_pkg.sv -----
// ============================================================================
// ustc_pkg: shared types and constants for the share token controller
// Field widths, register indexes, arithmetic unit modes and handshake structs.
// ============================================================================
package ustc_pkg;

    // field widths
    localparam int UTIL_W   = 7;
    localparam int TOTAL_W  = 20;
    localparam int CC_W     = 9;
    localparam int TPC_W    = 13;
    localparam int GRIDS_W  = 16;
    localparam int BLOCKS_W = 11;
    localparam int POOL_W   = 27;
    localparam int SHARE_W  = 20;
    localparam int IN_W     = 40;
    localparam int OUT_W    = 48;
    localparam int CFG_A_W  = 3;
    localparam int CFG_D_W  = 20;

    // arithmetic unit sizes
    localparam int ACC_W    = 40;
    localparam int OPB_W    = 13;
    localparam int STEP_W   = 6;
    localparam int INC_W    = 38;

    // configuration register indexes
    localparam logic [CFG_A_W-1:0] REG_TARGET = 3'd0;
    localparam logic [CFG_A_W-1:0] REG_IDLE   = 3'd1;
    localparam logic [CFG_A_W-1:0] REG_TOTAL  = 3'd2;
    localparam logic [CFG_A_W-1:0] REG_CORES  = 3'd3;
    localparam logic [CFG_A_W-1:0] REG_TPC    = 3'd4;

    // configuration reset values
    localparam logic [UTIL_W-1:0]  TARGET_RST = 7'd20;
    localparam logic [UTIL_W-1:0]  IDLE_RST   = 7'd2;
    localparam logic [TOTAL_W-1:0] TOTAL_RST  = 20'd1024;
    localparam logic [CC_W-1:0]    CORES_RST  = 9'd4;
    localparam logic [TPC_W-1:0]   TPC_RST    = 13'd1024;

    // item kinds
    localparam logic OP_SAMPLE = 1'b0;
    localparam logic OP_LAUNCH = 1'b1;

    // arithmetic unit modes
    localparam logic MODE_MUL = 1'b0;
    localparam logic MODE_DIV = 1'b1;

    // step counts of each pass through the unit
    localparam logic [STEP_W-1:0] STEPS_CC     = STEP_W'(CC_W);
    localparam logic [STEP_W-1:0] STEPS_TPC    = STEP_W'(TPC_W);
    localparam logic [STEP_W-1:0] STEPS_GAP    = STEP_W'(UTIL_W);
    localparam logic [STEP_W-1:0] STEPS_SCALE  = STEP_W'(UTIL_W + 1);
    localparam logic [STEP_W-1:0] STEPS_LAUNCH = STEP_W'(BLOCKS_W);
    localparam logic [STEP_W-1:0] STEPS_DIV    = STEP_W'(ACC_W);

    // share math constants: gap floor and the divide by 256
    localparam logic [UTIL_W-1:0] GAP_FLOOR = 7'd5;
    localparam int                INC_SHIFT = 8;

    // least pool level
    localparam logic signed [POOL_W+1:0] POOL_MIN = -29'sd67108864;

    typedef struct packed {
        logic              start;
        logic              mode;
        logic [STEP_W-1:0] steps;
    } mdu_req_t;

    typedef struct packed {
        logic busy;
        logic done;
    } mdu_rsp_t;

endpackage

// ----- rtl/ustc_mdu.sv -----
// ============================================================================
// ustc_mdu: iterative multiply / divide unit
// One shared 40-bit adder runs shift-add multiply or restoring divide steps.
// ============================================================================
module ustc_mdu (
    input  logic                     clk,
    input  logic                     rst_n,
    input  ustc_pkg::mdu_req_t       req,
    input  logic [ustc_pkg::ACC_W-1:0] opa,
    input  logic [ustc_pkg::OPB_W-1:0] opb,
    output ustc_pkg::mdu_rsp_t       rsp,
    output logic [ustc_pkg::ACC_W-1:0] result
);
    import ustc_pkg::*;

    logic              busy_reg;
    logic              done_reg;
    logic              mode_reg;
    logic [STEP_W-1:0] cnt_reg;
    logic [ACC_W-1:0]  acc_reg;
    logic [ACC_W-1:0]  mcand_reg;
    logic [OPB_W-1:0]  mplier_reg;

    logic [ACC_W-1:0]  rem_sh;
    logic [ACC_W-1:0]  add_x;
    logic [ACC_W-1:0]  add_y;
    logic [ACC_W:0]    add_sum;

    // shared adder: accumulate in multiply mode, trial subtract in divide mode
    always_comb
    begin
        rem_sh = {mcand_reg[ACC_W-2:0], acc_reg[ACC_W-1]};
        if (mode_reg == MODE_DIV)
        begin
            add_x = rem_sh;
            add_y = ~{{(ACC_W-OPB_W){1'b0}}, mplier_reg};
        end
        else
        begin
            add_x = acc_reg;
            add_y = mcand_reg;
        end
        add_sum = {1'b0, add_x} + {1'b0, add_y} + {{ACC_W{1'b0}}, mode_reg};
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end
        else
        begin
            done_reg <= 1'b0;
            if (req.start)
            begin
                busy_reg <= 1'b1;
                cnt_reg  <= req.steps;
            end
            else if (busy_reg)
            begin
                cnt_reg <= cnt_reg - 1'b1;
                if (cnt_reg == STEP_W'(1))
                begin
                    busy_reg <= 1'b0;
                    done_reg <= 1'b1;
                end
            end
        end
    end

    // datapath registers, no reset needed
    always_ff @(posedge clk)
    begin
        if (req.start)
        begin
            mode_reg   <= req.mode;
            mplier_reg <= opb;
            if (req.mode == MODE_DIV)
            begin
                acc_reg   <= opa;
                mcand_reg <= '0;
            end
            else
            begin
                acc_reg   <= '0;
                mcand_reg <= opa;
            end
        end
        else if (busy_reg)
        begin
            if (mode_reg == MODE_DIV)
            begin
                // carry out set: remainder covers divisor, take the difference
                mcand_reg <= add_sum[ACC_W] ? add_sum[ACC_W-1:0] : rem_sh;
                acc_reg   <= {acc_reg[ACC_W-2:0], add_sum[ACC_W]};
            end
            else
            begin
                if (mplier_reg[0])
                begin
                    acc_reg <= add_sum[ACC_W-1:0];
                end
                mcand_reg  <= {mcand_reg[ACC_W-2:0], 1'b0};
                mplier_reg <= {1'b0, mplier_reg[OPB_W-1:1]};
            end
        end
    end

    assign rsp.busy = busy_reg;
    assign rsp.done = done_reg;
    assign result   = acc_reg;

endmodule

// ----- rtl/utilization_share_token_controller.sv -----
// ============================================================================
// utilization_share_token_controller: feedback token bucket for a shared device
// Samples adjust a share and refill the token pool; launches draw tokens.
// ============================================================================
// Sequence: a launch takes one multiply; a sample takes three multiplies, plus
//   a further multiply and a 40-step divide when the gap exceeds half the target.
// Flow: one item at a time; the input is not ready again until the result is
//   loaded, which waits while the output is stalled. The iterative multiply/divide
//   unit works one bit per cycle. The result register frees the input.
// Reset: configuration registers take their defaults, share and pool clear
//   to zero, no clearing pass.
module utilization_share_token_controller (
    input  logic                              clk,
    input  logic                              rst_n,
    // configuration write port
    input  logic                              cfg_we,
    input  logic [ustc_pkg::CFG_A_W-1:0]      cfg_addr,
    input  logic [ustc_pkg::CFG_D_W-1:0]      cfg_wdata,
    // item input
    input  logic                              s_axis_tvalid,
    output logic                              s_axis_tready,
    input  logic [ustc_pkg::IN_W-1:0]         s_axis_tdata,  // utilization[6:0], grids[22:7],
                                                             // blocks[33:23], zero fill
    input  logic                              s_axis_tuser,  // op
    // result output
    output logic                              m_axis_tvalid,
    input  logic                              m_axis_tready,
    output logic [ustc_pkg::OUT_W-1:0]        m_axis_tdata   // granted[0], pool_level[27:1],
                                                             // share_now[47:28]
);
    import ustc_pkg::*;

    localparam logic [2:0] ST_IDLE   = 3'd0;
    localparam logic [2:0] ST_CC2    = 3'd1;
    localparam logic [2:0] ST_TPC    = 3'd2;
    localparam logic [2:0] ST_GAP    = 3'd3;
    localparam logic [2:0] ST_SCALE  = 3'd4;
    localparam logic [2:0] ST_DIV    = 3'd5;
    localparam logic [2:0] ST_LAUNCH = 3'd6;
    localparam logic [2:0] ST_FIN    = 3'd7;

    // configuration
    logic [UTIL_W-1:0]  target_reg;
    logic [UTIL_W-1:0]  idle_reg;
    logic [TOTAL_W-1:0] total_reg;
    logic [CC_W-1:0]    cores_reg;
    logic [TPC_W-1:0]   tpc_reg;

    // block state
    logic [SHARE_W-1:0]       share_reg, share_next;
    logic signed [POOL_W-1:0] pool_reg, pool_next;

    // sequencer and per-item registers
    logic [2:0]         state_reg, state_next;
    logic               op_reg, op_next;
    logic [UTIL_W-1:0]  util_reg, util_next;
    logic [UTIL_W-1:0]  gap_reg, gap_next;
    logic [INC_W-1:0]   inc_reg, inc_next;

    // result register
    logic               out_valid_reg, out_valid_next;
    logic [OUT_W-1:0]   out_data_reg, out_data_next;

    // arithmetic unit hookup
    mdu_req_t           mdu_req;
    mdu_rsp_t           mdu_rsp;
    logic [ACC_W-1:0]   mdu_a;
    logic [OPB_W-1:0]   mdu_b;
    logic [ACC_W-1:0]   mdu_res;

    // input fields
    logic               in_accept;
    logic [UTIL_W-1:0]  in_util;
    logic [GRIDS_W-1:0] in_grids;
    logic [BLOCKS_W-1:0] in_blocks;
    logic [UTIL_W-1:0]  in_diff;
    logic [UTIL_W-1:0]  in_gap;

    // finishing arithmetic
    logic               big_gap;
    logic [ACC_W-1:0]   inc_base;
    logic [INC_W:0]     up_sum;
    logic [SHARE_W-1:0] s_up, s_dn, s_val;
    logic signed [POOL_W:0]   add_sum;
    logic signed [POOL_W-1:0] add_pool;
    logic signed [POOL_W+1:0] launch_after;
    logic signed [POOL_W-1:0] launch_pool;
    logic               fin_granted;

    ustc_mdu u_mdu (
        .clk    (clk),
        .rst_n  (rst_n),
        .req    (mdu_req),
        .opa    (mdu_a),
        .opb    (mdu_b),
        .rsp    (mdu_rsp),
        .result (mdu_res)
    );

    assign s_axis_tready = (state_reg == ST_IDLE);
    assign in_accept     = s_axis_tvalid && s_axis_tready;
    assign in_util       = s_axis_tdata[6:0];
    assign in_grids      = s_axis_tdata[22:7];
    assign in_blocks     = s_axis_tdata[33:23];

    // distance from target, floored
    always_comb
    begin
        in_diff = (in_util > target_reg) ? (in_util - target_reg) : (target_reg - in_util);
        in_gap  = (in_diff < GAP_FLOOR) ? GAP_FLOOR : in_diff;
    end

    assign big_gap  = gap_reg > (target_reg >> 1);
    assign inc_base = mdu_res >> INC_SHIFT;

    // share step, saturating at zero and at the total
    always_comb
    begin
        up_sum = {{(INC_W+1-SHARE_W){1'b0}}, share_reg} + {1'b0, inc_reg};
        s_up   = (up_sum > {{(INC_W+1-TOTAL_W){1'b0}}, total_reg}) ? total_reg
                                                                   : up_sum[SHARE_W-1:0];
        s_dn   = (inc_reg > {{(INC_W-SHARE_W){1'b0}}, share_reg}) ? '0
                                                                  : share_reg - inc_reg[SHARE_W-1:0];
        s_val  = (util_reg <= target_reg) ? s_up : s_dn;
    end

    // pool refill capped at the total, launch draw saturated at the floor
    always_comb
    begin
        add_sum  = {pool_reg[POOL_W-1], pool_reg} + $signed({{(POOL_W+1-SHARE_W){1'b0}}, s_val});
        add_pool = (add_sum > $signed({{(POOL_W+1-TOTAL_W){1'b0}}, total_reg}))
                   ? $signed({{(POOL_W-TOTAL_W){1'b0}}, total_reg}) : add_sum[POOL_W-1:0];
        launch_after = {{2{pool_reg[POOL_W-1]}}, pool_reg}
                       - $signed({2'b00, inc_reg[POOL_W-1:0]});
        launch_pool  = (launch_after < POOL_MIN) ? POOL_MIN[POOL_W-1:0]
                                                 : launch_after[POOL_W-1:0];
    end

    // sequencer: walk the item through the shared unit
    always_comb
    begin
        state_next     = state_reg;
        op_next        = op_reg;
        util_next      = util_reg;
        gap_next       = gap_reg;
        inc_next       = inc_reg;
        share_next     = share_reg;
        pool_next      = pool_reg;
        out_valid_next = out_valid_reg;
        out_data_next  = out_data_reg;
        mdu_req        = '0;
        mdu_a          = '0;
        mdu_b          = '0;
        fin_granted    = 1'b1;

        if (m_axis_tready)
        begin
            out_valid_next = 1'b0;
        end

        case (state_reg)
            ST_IDLE:
            begin
                if (in_accept)
                begin
                    op_next   = s_axis_tuser;
                    util_next = in_util;
                    gap_next  = in_gap;
                    mdu_req.start = 1'b1;
                    mdu_req.mode  = MODE_MUL;
                    if (s_axis_tuser == OP_LAUNCH)
                    begin
                        mdu_a         = ACC_W'(in_grids);
                        mdu_b         = OPB_W'(in_blocks);
                        mdu_req.steps = STEPS_LAUNCH;
                        state_next    = ST_LAUNCH;
                    end
                    else
                    begin
                        mdu_a         = ACC_W'(cores_reg);
                        mdu_b         = OPB_W'(cores_reg);
                        mdu_req.steps = STEPS_CC;
                        state_next    = ST_CC2;
                    end
                end
            end
            ST_CC2:
            begin
                if (mdu_rsp.done)
                begin
                    mdu_req.start = 1'b1;
                    mdu_req.mode  = MODE_MUL;
                    mdu_req.steps = STEPS_TPC;
                    mdu_a         = mdu_res;
                    mdu_b         = tpc_reg;
                    state_next    = ST_TPC;
                end
            end
            ST_TPC:
            begin
                if (mdu_rsp.done)
                begin
                    mdu_req.start = 1'b1;
                    mdu_req.mode  = MODE_MUL;
                    mdu_req.steps = STEPS_GAP;
                    mdu_a         = mdu_res;
                    mdu_b         = OPB_W'(gap_reg);
                    state_next    = ST_GAP;
                end
            end
            ST_GAP:
            begin
                if (mdu_rsp.done)
                begin
                    inc_next = inc_base[INC_W-1:0];
                    if (big_gap)
                    begin
                        mdu_req.start = 1'b1;
                        mdu_req.mode  = MODE_MUL;
                        mdu_req.steps = STEPS_SCALE;
                        mdu_a         = inc_base;
                        mdu_b         = OPB_W'({gap_reg, 1'b0});
                        state_next    = ST_SCALE;
                    end
                    else
                    begin
                        state_next = ST_FIN;
                    end
                end
            end
            ST_SCALE:
            begin
                if (mdu_rsp.done)
                begin
                    mdu_req.start = 1'b1;
                    mdu_req.mode  = MODE_DIV;
                    mdu_req.steps = STEPS_DIV;
                    mdu_a         = mdu_res;
                    mdu_b         = OPB_W'({1'b0, target_reg} + 8'd1);
                    state_next    = ST_DIV;
                end
            end
            ST_DIV, ST_LAUNCH:
            begin
                if (mdu_rsp.done)
                begin
                    inc_next   = mdu_res[INC_W-1:0];
                    state_next = ST_FIN;
                end
            end
            ST_FIN:
            begin
                // commit state and load the result once the output is free
                if (!out_valid_reg || m_axis_tready)
                begin
                    if (op_reg == OP_LAUNCH)
                    begin
                        if (pool_reg < 0)
                        begin
                            fin_granted = 1'b0;
                        end
                        else
                        begin
                            pool_next = launch_pool;
                        end
                    end
                    else if (util_reg < idle_reg)
                    begin
                        pool_next = $signed({{(POOL_W-SHARE_W){1'b0}}, s_val});
                    end
                    else
                    begin
                        share_next = s_val;
                        pool_next  = add_pool;
                    end
                    out_valid_next = 1'b1;
                    out_data_next  = {share_next, pool_next, fin_granted};
                    state_next     = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            out_valid_reg <= 1'b0;
            share_reg     <= '0;
            pool_reg      <= '0;
            target_reg    <= TARGET_RST;
            idle_reg      <= IDLE_RST;
            total_reg     <= TOTAL_RST;
            cores_reg     <= CORES_RST;
            tpc_reg       <= TPC_RST;
        end
        else
        begin
            state_reg     <= state_next;
            out_valid_reg <= out_valid_next;
            share_reg     <= share_next;
            pool_reg      <= pool_next;
            if (cfg_we)
            begin
                case (cfg_addr)
                    REG_TARGET: target_reg <= cfg_wdata[UTIL_W-1:0];
                    REG_IDLE:   idle_reg   <= cfg_wdata[UTIL_W-1:0];
                    REG_TOTAL:  total_reg  <= cfg_wdata[TOTAL_W-1:0];
                    REG_CORES:  cores_reg  <= cfg_wdata[CC_W-1:0];
                    REG_TPC:    tpc_reg    <= cfg_wdata[TPC_W-1:0];
                    default:    ;
                endcase
            end
        end
    end

    // per-item payload, no reset
    always_ff @(posedge clk)
    begin
        op_reg       <= op_next;
        util_reg     <= util_next;
        gap_reg      <= gap_next;
        inc_reg      <= inc_next;
        out_data_reg <= out_data_next;
    end

    assign m_axis_tvalid = out_valid_reg;
    assign m_axis_tdata  = out_data_reg;

    // the unit is never mid-pass while the block takes a new item
    a_idle_unit_free: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == ST_IDLE) |-> !mdu_rsp.busy)
        else $error("arithmetic unit busy while idle");

    // a pass completes only in a state that waits for it
    a_done_in_wait: assert property (@(posedge clk) disable iff (!rst_n)
        mdu_rsp.done |-> (state_reg != ST_IDLE) && (state_reg != ST_FIN))
        else $error("arithmetic unit finished outside a wait state");

    // a new result appears only out of the finishing step
    a_load_from_fin: assert property (@(posedge clk) disable iff (!rst_n)
        $rose(out_valid_reg) |-> ($past(state_reg) == ST_FIN))
        else $error("result loaded outside the finishing step");

endmodule

// ----- tb/tb_utilization_share_token_controller.sv -----
// ----------------------------------------------------------------------------
// tb_utilization_share_token_controller: self-checking bench for the share
// token controller
// Drives utilization samples and launch requests over the input stream,
// rewrites the five control registers between phases, and checks every result
// beat against an in-bench model of the feedback token bucket or a hand-worked answer.
// ----------------------------------------------------------------------------
module tb_utilization_share_token_controller;
    timeunit 1ns;
    timeprecision 1ps;

    import ustc_pkg::*;

    localparam int PHASES          = 10;
    localparam int BEATS_PER_PHASE = 188;
    localparam int QUIET_LIMIT     = 3000;  // cycles with no beat on either side
    localparam int DRAIN_CYCLES    = 100;   // longest item latency plus margin
    localparam int PRINT_LIMIT     = 40;

    // result beat as it sits on m_axis_tdata, lowest field last
    typedef struct packed {
        logic [SHARE_W-1:0]       share_now;
        logic signed [POOL_W-1:0] pool_level;
        logic                     granted;
    } grant_result_t;

    // one row of the directed plan: a register write or an item
    typedef struct packed {
        logic                  is_cfg;
        logic [CFG_A_W-1:0]    reg_idx;
        logic [CFG_D_W-1:0]    reg_val;
        logic                  op;
        logic [UTIL_W-1:0]     util;
        logic [GRIDS_W-1:0]    grids;
        logic [BLOCKS_W-1:0]   blocks;
        logic                  checked;
        grant_result_t         want;
    } plan_row_t;

    logic                 clk = 1'b0;
    logic                 rst_n = 1'b0;
    logic                 cfg_we = 1'b0;
    logic [CFG_A_W-1:0]   cfg_addr = '0;
    logic [CFG_D_W-1:0]   cfg_wdata = '0;
    logic                 s_axis_tvalid = 1'b0;
    logic                 s_axis_tready;
    logic [IN_W-1:0]      s_axis_tdata = '0;
    logic                 s_axis_tuser = OP_SAMPLE;
    logic                 m_axis_tvalid;
    logic                 m_axis_tready = 1'b0;
    logic [OUT_W-1:0]     m_axis_tdata;

    utilization_share_token_controller DUT (
        .clk           (clk),
        .rst_n         (rst_n),
        .cfg_we        (cfg_we),
        .cfg_addr      (cfg_addr),
        .cfg_wdata     (cfg_wdata),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tuser  (s_axis_tuser),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata)
    );

    always #10 clk = ~clk;

    // ------------------------------------------------------------------
    // Model state: control registers and the bucket itself
    // ------------------------------------------------------------------
    logic [UTIL_W-1:0]   model_target = TARGET_RST;
    logic [UTIL_W-1:0]   model_idle   = IDLE_RST;
    logic [TOTAL_W-1:0]  model_total  = TOTAL_RST;
    logic [CC_W-1:0]     model_cores  = CORES_RST;
    logic [TPC_W-1:0]    model_tpc    = TPC_RST;
    logic [SHARE_W-1:0]  model_share  = '0;
    longint              model_pool   = 0;

    grant_result_t       pending_grants[$];
    plan_row_t           plan_q[$];

    int  error_count  = 0;
    int  n_samples    = 0;
    int  n_launches   = 0;
    int  n_refused    = 0;
    int  n_saturated  = 0;
    int  n_settings   = 0;
    int  n_results    = 0;
    int  quiet_cycles = 0;
    int  stall_left   = 0;
    int  stall_pick;
    bit  steady       = 1'b0;

    // ------------------------------------------------------------------
    // Share math: gap from target, floored, scaled, optionally boosted
    // ------------------------------------------------------------------
    function automatic longint unsigned share_after_sample(input logic [UTIL_W-1:0] util);
        longint unsigned tgt, gap, inc, cur, cap, u;
        tgt = 64'(model_target);
        cur = 64'(model_share);
        cap = 64'(model_total);
        u   = 64'(util);
        gap = (u > tgt) ? u - tgt : tgt - u;
        if (gap < 64'(GAP_FLOOR))
            gap = 64'(GAP_FLOOR);
        inc = (64'(model_cores) * 64'(model_cores) * 64'(model_tpc) * gap) >> INC_SHIFT;
        // large gap: boost by gap*2/(target+1)
        if (gap > tgt / 2)
            inc = inc * gap * 2 / (tgt + 1);
        if (u <= tgt)
            return (cur + inc > cap) ? cap : cur + inc;
        return (inc > cur) ? 64'd0 : cur - inc;
    endfunction

    // Advance the bucket by one item and give the result beat it yields
    task automatic token_bucket_step(input logic op, input logic [UTIL_W-1:0] util,
                                     input logic [GRIDS_W-1:0] grids,
                                     input logic [BLOCKS_W-1:0] blocks,
                                     output grant_result_t res);
        longint unsigned s;
        longint          sum;
        longint          draw;
        res.granted = 1'b1;
        if (op == OP_SAMPLE) begin
            n_samples++;
            s = share_after_sample(util);
            if (util < model_idle) begin
                // idle device: share loads the pool outright
                model_pool = longint'(s);
            end
            else begin
                model_share = s[SHARE_W-1:0];
                sum = model_pool + longint'(s);
                if (sum > longint'(64'(model_total)))
                    sum = longint'(64'(model_total));
                model_pool = sum;
            end
        end
        else begin
            n_launches++;
            draw = longint'(64'(grids)) * longint'(64'(blocks));
            if (model_pool < 0) begin
                res.granted = 1'b0;
                n_refused++;
            end
            else begin
                model_pool = model_pool - draw;
                if (model_pool < POOL_MIN) begin
                    model_pool = POOL_MIN;
                    n_saturated++;
                end
            end
        end
        res.pool_level = model_pool[POOL_W-1:0];
        res.share_now  = model_share;
    endtask

    task automatic flag_mismatch(input string what, input longint got, input longint want);
        error_count++;
        if (error_count <= PRINT_LIMIT)
            $display("%0t: %s got %0d want %0d", $realtime, what, got, want);
    endtask

    // Gap length: mostly none or short, now and then long
    function automatic int pick_gap();
        int r;
        if (steady)
            return 0;
        r = $urandom_range(0, 99);
        if (r < 50)
            return 0;
        if (r < 85)
            return $urandom_range(1, 3);
        if (r < 97)
            return $urandom_range(4, 12);
        return $urandom_range(20, 60);
    endfunction

    // ------------------------------------------------------------------
    // Sender side: hold one beat until it is taken, then log the grant
    // ------------------------------------------------------------------
    task automatic send_beat(input logic op, input logic [UTIL_W-1:0] util,
                             input logic [GRIDS_W-1:0] grids,
                             input logic [BLOCKS_W-1:0] blocks,
                             input logic checked, input grant_result_t want);
        int            gap;
        grant_result_t res;
        gap = pick_gap();
        if (gap > 0) begin
            s_axis_tvalid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        s_axis_tvalid <= 1'b1;
        s_axis_tuser  <= op;
        s_axis_tdata  <= {{(IN_W - UTIL_W - GRIDS_W - BLOCKS_W){1'b0}}, blocks, grids, util};
        @(posedge clk);
        while (!s_axis_tready)
            @(posedge clk);
        token_bucket_step(op, util, grids, blocks, res);
        // directed rows with a hand-worked answer use it instead of the model
        pending_grants.push_back(checked ? want : res);
    endtask

    // Drop valid and wait until every grant has come back
    task automatic wait_drained();
        s_axis_tvalid <= 1'b0;
        while (pending_grants.size() != 0)
            @(posedge clk);
        repeat (4) @(posedge clk);
    endtask

    task automatic write_reg(input logic [CFG_A_W-1:0] idx, input logic [CFG_D_W-1:0] val);
        cfg_we    <= 1'b1;
        cfg_addr  <= idx;
        cfg_wdata <= val;
        @(posedge clk);
        case (idx)
            REG_TARGET: model_target = val[UTIL_W-1:0];
            REG_IDLE:   model_idle   = val[UTIL_W-1:0];
            REG_TOTAL:  model_total  = val[TOTAL_W-1:0];
            REG_CORES:  model_cores  = val[CC_W-1:0];
            REG_TPC:    model_tpc    = val[TPC_W-1:0];
            default:    ;
        endcase
        cfg_we <= 1'b0;
        @(posedge clk);
    endtask

    task automatic add_cfg(input logic [CFG_A_W-1:0] idx, input logic [CFG_D_W-1:0] val);
        plan_row_t row;
        row = '0;
        row.is_cfg  = 1'b1;
        row.reg_idx = idx;
        row.reg_val = val;
        plan_q.push_back(row);
    endtask

    task automatic add_item(input logic op, input int util, input int grids, input int blocks);
        plan_row_t row;
        row = '0;
        row.op     = op;
        row.util   = util[UTIL_W-1:0];
        row.grids  = grids[GRIDS_W-1:0];
        row.blocks = blocks[BLOCKS_W-1:0];
        plan_q.push_back(row);
    endtask

    task automatic add_checked(input logic op, input int util, input int grids,
                               input int blocks, input logic granted, input int pool,
                               input int share);
        add_item(op, util, grids, blocks);
        plan_q[$].checked         = 1'b1;
        plan_q[$].want.granted    = granted;
        plan_q[$].want.pool_level = pool[POOL_W-1:0];
        plan_q[$].want.share_now  = share[SHARE_W-1:0];
    endtask

    // ------------------------------------------------------------------
    // Receiver side: random stalls, none in steady stretches
    // ------------------------------------------------------------------
    always @(posedge clk) begin
        if (rst_n) begin
            if (stall_left > 0) begin
                m_axis_tready <= 1'b0;
                stall_left    <= stall_left - 1;
            end
            else begin
                stall_pick = (steady || $urandom_range(0, 3) != 0) ? 0 : pick_gap();
                if (stall_pick > 0) begin
                    m_axis_tready <= 1'b0;
                    stall_left    <= stall_pick - 1;
                end
                else begin
                    m_axis_tready <= 1'b1;
                end
            end
        end
    end

    // ------------------------------------------------------------------
    // Checker: each result beat against the oldest pending grant
    // ------------------------------------------------------------------
    always @(posedge clk) begin
        grant_result_t got;
        grant_result_t want;
        if (rst_n && m_axis_tvalid && m_axis_tready) begin
            got = m_axis_tdata;
            n_results++;
            if (pending_grants.size() == 0) begin
                flag_mismatch("result beat with nothing pending, pool", $signed(got.pool_level), 0);
            end
            else begin
                want = pending_grants.pop_front();
                if (got.granted !== want.granted)
                    flag_mismatch("granted", got.granted, want.granted);
                if (got.pool_level !== want.pool_level)
                    flag_mismatch("pool_level", $signed(got.pool_level),
                                  $signed(want.pool_level));
                if (got.share_now !== want.share_now)
                    flag_mismatch("share_now", got.share_now, want.share_now);
            end
        end
    end

    // ------------------------------------------------------------------
    // Watchdog: end the run when the block goes quiet for too long
    // ------------------------------------------------------------------
    always @(posedge clk) begin
        if (rst_n) begin
            if ((s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready)) begin
                quiet_cycles <= 0;
            end
            else if (quiet_cycles >= QUIET_LIMIT) begin
                $display("%0t: no beat for %0d cycles, %0d grants still pending",
                         $realtime, QUIET_LIMIT, pending_grants.size());
                $display("tb_utilization_share_token_controller: errors");
                $finish;
            end
            else begin
                quiet_cycles <= quiet_cycles + 1;
            end
        end
    end

    // ------------------------------------------------------------------
    // Main sequence
    // ------------------------------------------------------------------
    initial begin
        plan_row_t           row;
        grant_result_t       none;
        logic [UTIL_W-1:0]   r_util;
        logic [GRIDS_W-1:0]  r_grids;
        logic [BLOCKS_W-1:0] r_blocks;
        logic                r_op;
        int                  pick;
        int                  p;
        int                  i;

        none = '0;

        // Directed plan, from reset defaults: zero-size launch, drain into
        // a negative pool, refusal, plain and boosted samples, idle load,
        // the largest in-range launch, a saturating launch, out-of-range
        // utilization.
        add_checked(OP_LAUNCH, 0, 0, 0, 1'b1, 0, 0);
        add_checked(OP_LAUNCH, 0, 1, 1, 1'b1, -1, 0);
        add_checked(OP_LAUNCH, 0, 5, 5, 1'b0, -1, 0);
        add_checked(OP_SAMPLE, 20, 0, 0, 1'b1, 319, 320);
        add_checked(OP_SAMPLE, 0, 0, 0, 1'b1, 1024, 320);
        add_checked(OP_SAMPLE, 100, 0, 0, 1'b1, 1024, 0);
        add_checked(OP_LAUNCH, 0, 65535, 1024, 1'b1, -67106816, 0);
        add_checked(OP_LAUNCH, 0, 65535, 1024, 1'b0, -67106816, 0);
        add_checked(OP_SAMPLE, 0, 0, 0, 1'b1, 1024, 0);
        add_checked(OP_LAUNCH, 0, 65535, 2047, 1'b1, -67108864, 0);
        add_checked(OP_LAUNCH, 0, 1, 1, 1'b0, -67108864, 0);
        add_checked(OP_SAMPLE, 127, 0, 0, 1'b1, -67108864, 0);
        add_item(OP_SAMPLE, 1, 65535, 2047);
        // largest increments: share and pool pinned at the top
        add_cfg(REG_TOTAL, 20'hFFFFF);
        add_cfg(REG_CORES, 20'd256);
        add_cfg(REG_TPC, 20'd4096);
        add_item(OP_SAMPLE, 0, 0, 0);
        add_item(OP_SAMPLE, 10, 0, 0);
        // total lowered under share and pool; tiny increments
        add_cfg(REG_TOTAL, 20'd100);
        add_cfg(REG_CORES, 20'd1);
        add_cfg(REG_TPC, 20'd1);
        add_item(OP_SAMPLE, 30, 0, 0);
        add_item(OP_SAMPLE, 10, 0, 0);
        // target and idle at opposite extremes
        add_cfg(REG_TARGET, 20'd0);
        add_cfg(REG_IDLE, 20'd100);
        add_item(OP_SAMPLE, 50, 0, 0);
        add_item(OP_LAUNCH, 0, 3, 7);
        add_cfg(REG_TARGET, 20'd100);
        add_cfg(REG_IDLE, 20'd0);
        add_item(OP_SAMPLE, 100, 0, 0);
        add_item(OP_SAMPLE, 0, 0, 0);

        // hold reset, then release it on an edge
        repeat (2) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        foreach (plan_q[k]) begin
            row = plan_q[k];
            if (row.is_cfg) begin
                wait_drained();
                write_reg(row.reg_idx, row.reg_val);
            end
            else begin
                send_beat(row.op, row.util, row.grids, row.blocks, row.checked, row.want);
            end
        end

        // Random phases: each rewrites all five registers while idle
        for (p = 0; p < PHASES; p++) begin
            wait_drained();
            steady = (p % 4 == 3);
            n_settings++;
            case (p)
                0: begin
                    write_reg(REG_TARGET, 20'd0);
                    write_reg(REG_IDLE, 20'd0);
                    write_reg(REG_TOTAL, 20'd0);
                    write_reg(REG_CORES, 20'd1);
                    write_reg(REG_TPC, 20'd1);
                end
                1: begin
                    write_reg(REG_TARGET, 20'd100);
                    write_reg(REG_IDLE, 20'd100);
                    write_reg(REG_TOTAL, 20'hFFFFF);
                    write_reg(REG_CORES, 20'd256);
                    write_reg(REG_TPC, 20'd4096);
                end
                2: begin
                    write_reg(REG_TARGET, CFG_D_W'(TARGET_RST));
                    write_reg(REG_IDLE, CFG_D_W'(IDLE_RST));
                    write_reg(REG_TOTAL, CFG_D_W'(TOTAL_RST));
                    write_reg(REG_CORES, CFG_D_W'(CORES_RST));
                    write_reg(REG_TPC, CFG_D_W'(TPC_RST));
                end
                default: begin
                    write_reg(REG_TARGET, CFG_D_W'($urandom_range(0, 100)));
                    write_reg(REG_IDLE, CFG_D_W'(($urandom_range(0, 3) == 0) ?
                              $urandom_range(0, 100) : $urandom_range(0, 15)));
                    write_reg(REG_TOTAL, CFG_D_W'(($urandom_range(0, 1) == 0) ?
                              $urandom_range(0, 4095) : $urandom_range(0, 20'hFFFFF)));
                    write_reg(REG_CORES, CFG_D_W'(($urandom_range(0, 1) == 0) ?
                              $urandom_range(1, 8) : $urandom_range(1, 256)));
                    write_reg(REG_TPC, CFG_D_W'($urandom_range(1, 4096)));
                end
            endcase

            for (i = 0; i < BEATS_PER_PHASE; i++) begin
                r_op = $urandom_range(0, 1) ? OP_LAUNCH : OP_SAMPLE;
                // utilization mostly in range, sometimes up to the field top
                r_util = UTIL_W'(($urandom_range(0, 9) == 0) ? $urandom_range(101, 127)
                                                             : $urandom_range(0, 100));
                // launch sizes mostly small so the pool swings both ways
                pick = $urandom_range(0, 99);
                if (pick < 70) begin
                    r_grids  = GRIDS_W'($urandom_range(0, 15));
                    r_blocks = BLOCKS_W'($urandom_range(0, 63));
                end
                else if (pick < 90) begin
                    r_grids  = GRIDS_W'($urandom_range(0, 1023));
                    r_blocks = BLOCKS_W'($urandom_range(0, 1024));
                end
                else if (pick < 97) begin
                    r_grids  = GRIDS_W'($urandom_range(0, 65535));
                    r_blocks = BLOCKS_W'($urandom_range(0, 2047));
                end
                else begin
                    r_grids  = $urandom_range(0, 1) ? 16'hFFFF : 16'h0000;
                    r_blocks = $urandom_range(0, 1) ? 11'h7FF : 11'd1024;
                end
                send_beat(r_op, r_util, r_grids, r_blocks, 1'b0, none);
            end
        end

        // Drain, then give the block its worst-case latency to misbehave
        wait_drained();
        repeat (DRAIN_CYCLES) @(posedge clk);
        if (pending_grants.size() != 0)
            flag_mismatch("grants left pending at end", pending_grants.size(), 0);

        $display("ran %0d samples and %0d launches over %0d random register settings",
                 n_samples, n_launches, n_settings);
        $display("%0d launches refused on a negative pool, %0d clamped at the pool floor",
                 n_refused, n_saturated);
        if (error_count == 0) begin
            $display("tb_utilization_share_token_controller: clean");
        end
        else begin
            $display("%0d mismatches over %0d result beats", error_count, n_results);
            $display("tb_utilization_share_token_controller: errors");
        end
        $finish;
    end

endmodule
